[design/double_ended_queue_defines.svh]
// Assertion macros for the double-ended queue.
// Included by design/double_ended_queue.sv; no other dependencies.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("double_ended_queue: assertion failed");
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("double_ended_queue: assertion failed");
`else
`define DEQ_ASSERT(lbl, clk, rstn, prop)
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/deq_pkg.sv]
// Shared types and constants for the double-ended queue.
// No dependencies.
package deq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic signed [VALUE_W-1:0] EMPTY_WORD = -32'sd1;

endpackage

[design/double_ended_queue.sv]
// Double-ended queue of signed 32-bit words over a ring-buffer memory.
// Depends on deq_pkg and double_ended_queue_defines.svh.
//
// Usage:
//   Command channel: drive i_mode and i_push_value with i_start high; the
//   transaction is taken at a rising edge where i_start is high and o_busy
//   is low. Modes: push front, push back, pop front, pop back.
//   Result channel: o_done is high for exactly one cycle, in the cycle after
//   the transaction is taken, with o_pop_value, o_status and o_entry_count.
//   The receiver cannot stall; results must be taken when o_done is high.
// Throughput:
//   One transaction is taken every cycle once o_busy is low: indices and
//   the count live in registers, each transaction touches at most one slot of
//   memory through its single write port or its single registered read port.
//   A pop that follows a push to the same slot reads after the write edge.
// Reset:
//   i_rst_n (synchronous, active low) empties the queue and holds o_busy
//   high through the cycle after reset. The slot memory is not cleared; a
//   slot is read only after it was written.
module double_ended_queue #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [1:0]                            i_mode,
    input  logic signed [deq_pkg::VALUE_W-1:0]    i_push_value,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic signed [deq_pkg::VALUE_W-1:0]    o_pop_value,
    output logic [1:0]                            o_status,
    output logic [deq_pkg::COUNT_OUT_W-1:0]       o_entry_count
);

`include "double_ended_queue_defines.svh"

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [deq_pkg::VALUE_W-1:0] mem [DEPTH];

    logic                               r_busy;
    logic                               r_done;
    logic                               r_from_mem;
    deq_pkg::t_status                   r_status;
    logic [IW-1:0]                      r_front;
    logic [IW-1:0]                      r_back;
    logic [CW-1:0]                      r_count;
    logic signed [deq_pkg::VALUE_W-1:0] r_rd_data;

    logic                               accept;
    deq_pkg::t_mode                     mode;
    logic                               is_push;
    logic                               is_full;
    logic                               is_empty;
    logic [IW-1:0]                      front_dec;
    logic [IW-1:0]                      front_inc;
    logic [IW-1:0]                      back_dec;
    logic [IW-1:0]                      back_inc;
    logic                               we;
    logic                               re;
    logic [IW-1:0]                      wa;
    logic [IW-1:0]                      ra;
    logic [IW-1:0]                      n_front;
    logic [IW-1:0]                      n_back;
    logic [CW-1:0]                      n_count;
    deq_pkg::t_status                   n_status;

    assign accept   = i_start && !r_busy;
    assign mode     = deq_pkg::t_mode'(i_mode);
    assign is_push  = (mode == deq_pkg::MODE_PUSH_FRONT) || (mode == deq_pkg::MODE_PUSH_BACK);
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - IW'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + IW'(1);
    assign back_dec  = (r_back == '0) ? LAST_IDX : r_back - IW'(1);
    assign back_inc  = (r_back == LAST_IDX) ? '0 : r_back + IW'(1);

    always_comb begin
        we       = 1'b0;
        re       = 1'b0;
        wa       = r_back;
        ra       = r_front;
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = deq_pkg::ST_DONE;
        if (is_push && is_full) begin
            n_status = deq_pkg::ST_FULL;
        end else if (!is_push && is_empty) begin
            n_status = deq_pkg::ST_EMPTY;
        end else begin
            case (mode)
                deq_pkg::MODE_PUSH_FRONT: begin
                    we      = accept;
                    wa      = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
                deq_pkg::MODE_PUSH_BACK: begin
                    we      = accept;
                    wa      = r_back;
                    n_back  = back_inc;
                    n_count = r_count + CW'(1);
                end
                deq_pkg::MODE_POP_FRONT: begin
                    re      = accept;
                    ra      = r_front;
                    n_front = front_inc;
                    n_count = r_count - CW'(1);
                end
                deq_pkg::MODE_POP_BACK: begin
                    re      = accept;
                    ra      = back_dec;
                    n_back  = back_dec;
                    n_count = r_count - CW'(1);
                end
                default: begin
                    n_status = deq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= i_push_value;
        end
        if (re) begin
            r_rd_data <= mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_done     <= 1'b0;
            r_from_mem <= 1'b0;
            r_status   <= deq_pkg::ST_DONE;
            r_front    <= '0;
            r_back     <= '0;
            r_count    <= '0;
        end else begin
            r_busy <= 1'b0;
            r_done <= accept;
            if (accept) begin
                r_from_mem <= re;
                r_status   <= n_status;
                r_front    <= n_front;
                r_back     <= n_back;
                r_count    <= n_count;
            end
        end
    end

    assign o_busy        = r_busy;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_count = deq_pkg::COUNT_OUT_W'(r_count);
    assign o_pop_value   = (r_status == deq_pkg::ST_EMPTY) ? deq_pkg::EMPTY_WORD :
                           r_from_mem ? r_rd_data : '0;

    `DEQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `DEQ_ASSERT(a_done_follows, i_clk, i_rst_n, accept |=> r_done)
    `DEQ_ASSERT(a_idx_meet, i_clk, i_rst_n, (is_empty || is_full) |-> (r_front == r_back))
    `DEQ_ASSERT(a_empty_status, i_clk, i_rst_n, (r_done && r_status == deq_pkg::ST_EMPTY) |-> is_empty)
    `DEQ_ASSERT(a_push_grows, i_clk, i_rst_n,
        (accept && is_push && !is_full) |=> (r_count == $past(r_count) + CW'(1)))
    `DEQ_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_busy && !r_done))

endmodule
